/* rtl/sbd_pkg.sv */
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and constants of the supersample box downsampler: channel
// and coordinate widths, configuration register indexes, queue depth.
// ----------------------------------------------------------------------------
package sbd_pkg;

  // default sizing of the line store and the block side
  localparam int MAX_WIDTH_DEF       = 1024;
  localparam int MAX_SAMPLE_RATE_DEF = 4;

  // output frame height is capped at this many rows
  localparam int HEIGHT_CAP = 1024;

  // field widths
  localparam int CHAN_W     = 8;
  localparam int COORD_W    = 10;
  localparam int RATE_CFG_W = 3;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 2'd2;

  // reset values of the configuration registers
  localparam logic [RATE_CFG_W-1:0] RATE_RST   = 3'd1;
  localparam logic [CFG_W-1:0]      WIDTH_RST  = 11'd1024;
  localparam logic [CFG_W-1:0]      HEIGHT_RST = 11'd1024;

  // entries of the queue between front and back end (power of two)
  localparam int QUEUE_DEPTH = 4;

  // one rgba sample or pixel
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  // position of a sample inside its block and frame
  typedef struct packed {
    logic first;
    logic last;
    logic fend;
  } blk_flags_t;

endpackage

/* rtl/sbd_queue.sv */
// ----------------------------------------------------------------------------
// sbd_queue
// Small flop-based fifo that decouples the sample front end from the
// accumulate back end.
// ----------------------------------------------------------------------------
module sbd_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  // status
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = entry_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

/* rtl/sbd_front.sv */
// ----------------------------------------------------------------------------
// sbd_front
// Holds the configuration, tracks the sample position in the supersampled
// frame and tags every accepted sample with its block column, block row and
// first/last/frame-end marks. After reset or a configuration write it
// recomputes frame sizes and splits the kept position into block and
// in-block parts with a bit-serial divider.
// ----------------------------------------------------------------------------
module sbd_front #(
  parameter int MAX_WIDTH       = sbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SAMPLE_RATE = sbd_pkg::MAX_SAMPLE_RATE_DEF,
  localparam int BX_W   = $clog2(MAX_WIDTH),
  localparam int RATE_W = $clog2(MAX_SAMPLE_RATE + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [sbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sbd_pkg::CFG_W-1:0]           cfg_wdata,
  // samples in
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sbd_pkg::rgba_t                      in_pix,
  // tagged samples to the queue
  output logic                                push,
  output sbd_pkg::rgba_t                      push_pix,
  output logic [BX_W-1:0]                     push_bx,
  output logic [sbd_pkg::COORD_W-1:0]         push_by,
  output sbd_pkg::blk_flags_t                 push_flags,
  input  logic                                q_full,
  // block side for the back end
  output logic [RATE_W-1:0]                   blk_rate
);

  import sbd_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH * MAX_SAMPLE_RATE);
  localparam int ROW_W  = $clog2(HEIGHT_CAP * MAX_SAMPLE_RATE);
  localparam int CNT_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int STEP_W = $clog2(CNT_W + 1);
  localparam int EW_W   = $clog2(MAX_WIDTH + 1);
  localparam int EH_W   = $clog2(HEIGHT_CAP + 1);

  typedef enum logic [1:0] {
    S_CALC,
    S_WRAP,
    S_DIV,
    S_RUN
  } state_t;

  state_t                  state_r;
  state_t                  state_nxt;
  logic [RATE_CFG_W-1:0]   rate_cfg_r;
  logic [CFG_W-1:0]        width_cfg_r;
  logic [CFG_W-1:0]        height_cfg_r;
  logic [RATE_W-1:0]       rate_r;
  logic [RATE_W-1:0]       rate_m1_r;
  logic [COL_W-1:0]        sw_m1_r;
  logic [ROW_W-1:0]        sh_m1_r;
  logic [COL_W-1:0]        col_r;
  logic [ROW_W-1:0]        row_r;
  logic [BX_W-1:0]         bx_r;
  logic [COORD_W-1:0]      by_r;
  logic [RATE_W-1:0]       cx_r;
  logic [RATE_W-1:0]       cy_r;
  logic [CNT_W-1:0]        dcol_r;
  logic [CNT_W-1:0]        drow_r;
  logic [RATE_W-1:0]       rcol_r;
  logic [RATE_W-1:0]       rrow_r;
  logic [STEP_W-1:0]       step_r;

  logic [RATE_W-1:0]       rate_eff;
  logic [EW_W-1:0]         w_eff;
  logic [EH_W-1:0]         h_eff;
  logic [RATE_W:0]         trial_col;
  logic [RATE_W:0]         trial_row;
  logic                    col_ge;
  logic                    row_ge;
  logic [RATE_W-1:0]       rem_col_nxt;
  logic [RATE_W-1:0]       rem_row_nxt;
  logic [CNT_W-1:0]        dcol_nxt;
  logic [CNT_W-1:0]        drow_nxt;
  logic                    at_col_end;
  logic                    at_row_end;
  logic                    cx_end;
  logic                    cy_end;

  // clamp configuration to the supported range
  always_comb begin
    if (rate_cfg_r == '0) begin
      rate_eff = RATE_W'(1);
    end else if (int'(rate_cfg_r) > MAX_SAMPLE_RATE) begin
      rate_eff = RATE_W'(MAX_SAMPLE_RATE);
    end else begin
      rate_eff = RATE_W'(rate_cfg_r);
    end
    if (width_cfg_r == '0) begin
      w_eff = EW_W'(1);
    end else if (int'(width_cfg_r) > MAX_WIDTH) begin
      w_eff = EW_W'(MAX_WIDTH);
    end else begin
      w_eff = EW_W'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      h_eff = EH_W'(1);
    end else if (int'(height_cfg_r) > HEIGHT_CAP) begin
      h_eff = EH_W'(HEIGHT_CAP);
    end else begin
      h_eff = EH_W'(height_cfg_r);
    end
  end

  // one restoring division step for column and row
  always_comb begin
    trial_col   = {rcol_r, dcol_r[CNT_W-1]};
    trial_row   = {rrow_r, drow_r[CNT_W-1]};
    col_ge      = (trial_col >= {1'b0, rate_r});
    row_ge      = (trial_row >= {1'b0, rate_r});
    rem_col_nxt = col_ge ? RATE_W'(trial_col - {1'b0, rate_r}) : RATE_W'(trial_col);
    rem_row_nxt = row_ge ? RATE_W'(trial_row - {1'b0, rate_r}) : RATE_W'(trial_row);
    dcol_nxt    = {dcol_r[CNT_W-2:0], col_ge};
    drow_nxt    = {drow_r[CNT_W-2:0], row_ge};
  end

  // next setup state; any register write reruns the setup sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CALC: state_nxt = S_WRAP;
      S_WRAP: state_nxt = S_DIV;
      S_DIV: begin
        if (step_r == STEP_W'(CNT_W - 1)) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: state_nxt = S_RUN;
      default: state_nxt = S_CALC;
    endcase
    if (cfg_we) begin
      state_nxt = S_CALC;
    end
  end

  // position flags
  assign at_col_end = (col_r == sw_m1_r);
  assign at_row_end = (row_r == sh_m1_r);
  assign cx_end     = (cx_r == rate_m1_r);
  assign cy_end     = (cy_r == rate_m1_r);

  // handshake and tagged sample
  assign in_stall         = (state_r != S_RUN) || q_full;
  assign push             = in_valid && !in_stall;
  assign push_pix         = in_pix;
  assign push_bx          = bx_r;
  assign push_by          = by_r;
  assign push_flags.first = (cx_r == '0) && (cy_r == '0);
  assign push_flags.last  = cx_end && cy_end;
  assign push_flags.fend  = at_col_end && at_row_end;
  assign blk_rate         = rate_r;

  // configuration, setup sequence and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CALC;
      rate_cfg_r   <= RATE_RST;
      width_cfg_r  <= WIDTH_RST;
      height_cfg_r <= HEIGHT_RST;
      col_r        <= '0;
      row_r        <= '0;
      step_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        priority case (cfg_index)
          CFG_BLOCK_SIDE:    rate_cfg_r   <= cfg_wdata[RATE_CFG_W-1:0];
          CFG_TARGET_WIDTH:  width_cfg_r  <= cfg_wdata;
          CFG_TARGET_HEIGHT: height_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_CALC: begin
          rate_r    <= rate_eff;
          rate_m1_r <= rate_eff - 1'b1;
          sw_m1_r   <= COL_W'(w_eff * rate_eff - 1);
          sh_m1_r   <= ROW_W'(h_eff * rate_eff - 1);
        end
        S_WRAP: begin
          // a position outside the new frame restarts at zero
          if (col_r > sw_m1_r) begin
            col_r  <= '0;
            dcol_r <= '0;
          end else begin
            dcol_r <= CNT_W'(col_r);
          end
          if (row_r > sh_m1_r) begin
            row_r  <= '0;
            drow_r <= '0;
          end else begin
            drow_r <= CNT_W'(row_r);
          end
          rcol_r  <= '0;
          rrow_r  <= '0;
          step_r  <= '0;
        end
        S_DIV: begin
          dcol_r <= dcol_nxt;
          drow_r <= drow_nxt;
          rcol_r <= rem_col_nxt;
          rrow_r <= rem_row_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(CNT_W - 1)) begin
            bx_r    <= BX_W'(dcol_nxt);
            by_r    <= COORD_W'(drow_nxt);
            cx_r    <= rem_col_nxt;
            cy_r    <= rem_row_nxt;
          end
        end
        S_RUN: begin
          if (push) begin
            if (at_col_end) begin
              col_r <= '0;
              bx_r  <= '0;
              cx_r  <= '0;
              if (at_row_end) begin
                row_r <= '0;
                by_r  <= '0;
                cy_r  <= '0;
              end else begin
                row_r <= row_r + 1'b1;
                if (cy_end) begin
                  cy_r <= '0;
                  by_r <= by_r + 1'b1;
                end else begin
                  cy_r <= cy_r + 1'b1;
                end
              end
            end else begin
              col_r <= col_r + 1'b1;
              if (cx_end) begin
                cx_r <= '0;
                bx_r <= bx_r + 1'b1;
              end else begin
                cx_r <= cx_r + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cx_r <= rate_m1_r) && (cy_r <= rate_m1_r) &&
                           (col_r <= sw_m1_r) && (row_r <= sh_m1_r))
    else $error("sample position outside the frame");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !at_col_end |=> col_r == $past(col_r) + 1'b1)
    else $error("column counter did not advance");
`endif

endmodule

/* rtl/sbd_back.sv */
// ----------------------------------------------------------------------------
// sbd_back
// Reads tagged samples from the queue, accumulates them into the line store
// of block sums, and on the last sample of a block divides the sums by the
// block area through a reciprocal multiply and loads the output register.
// ----------------------------------------------------------------------------
module sbd_back #(
  parameter int MAX_WIDTH       = sbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SAMPLE_RATE = sbd_pkg::MAX_SAMPLE_RATE_DEF,
  localparam int BX_W   = $clog2(MAX_WIDTH),
  localparam int RATE_W = $clog2(MAX_SAMPLE_RATE + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // queue side
  input  logic                          q_empty,
  output logic                          q_pop,
  input  sbd_pkg::rgba_t                q_pix,
  input  logic [BX_W-1:0]               q_bx,
  input  logic [sbd_pkg::COORD_W-1:0]   q_by,
  input  sbd_pkg::blk_flags_t           q_flags,
  input  logic [RATE_W-1:0]             blk_rate,
  // pixels out
  output logic                          out_valid,
  input  logic                          out_stall,
  output sbd_pkg::rgba_t                out_pix,
  output logic [sbd_pkg::COORD_W-1:0]   out_col,
  output logic [sbd_pkg::COORD_W-1:0]   out_row,
  output logic                          out_fend
);

  import sbd_pkg::*;

  localparam int NCH    = 4;
  localparam int SUM_W  = CHAN_W + 2 * $clog2(MAX_SAMPLE_RATE);
  localparam int DIV_W  = $clog2(MAX_SAMPLE_RATE * MAX_SAMPLE_RATE + 1);
  localparam int SH     = SUM_W + DIV_W;
  localparam int M_W    = SH + 1;
  localparam int PROD_W = SUM_W + M_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ACC,
    B_MUL,
    B_OUT
  } state_t;

  state_t                       state_r;
  logic [NCH*SUM_W-1:0]         mem [MAX_WIDTH];
  logic [NCH*SUM_W-1:0]         rd_data_r;
  rgba_t                        pix_r;
  logic [BX_W-1:0]              bx_r;
  logic [COORD_W-1:0]           by_r;
  blk_flags_t                   flags_r;
  logic [NCH-1:0][SUM_W-1:0]    sum_r;
  logic [NCH-1:0][PROD_W-1:0]   prod_r;
  logic                         out_valid_r;
  rgba_t                        out_pix_r;
  logic [COORD_W-1:0]           out_col_r;
  logic [COORD_W-1:0]           out_row_r;
  logic                         out_fend_r;

  logic [M_W-1:0]               recip_tab [MAX_SAMPLE_RATE+1];
  logic [NCH-1:0][CHAN_W-1:0]   chan;
  logic [NCH-1:0][SUM_W-1:0]    sum;
  logic [NCH*SUM_W-1:0]         sum_word;
  logic [M_W-1:0]               recip;
  logic                         mem_we;
  logic                         out_free;
  logic                         out_load;

  // ceil(2^SH / rate^2): exact floor division for every block sum
  for (genvar g = 0; g <= MAX_SAMPLE_RATE; g++) begin : g_recip
    localparam longint D = (g == 0) ? 64'd1 : longint'(g) * longint'(g);
    localparam longint M = ((longint'(1) << SH) + D - 1) / D;
    assign recip_tab[g] = M_W'(M);
  end

  assign recip = recip_tab[blk_rate];

  // accumulate: first sample of a block overwrites its entry
  // channel 0 is red, channel 3 is alpha
  assign chan = {pix_r.alpha, pix_r.blue, pix_r.green, pix_r.red};
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (flags_r.first) begin
        sum[c] = SUM_W'(chan[c]);
      end else begin
        sum[c] = rd_data_r[c*SUM_W +: SUM_W] + SUM_W'(chan[c]);
      end
      sum_word[c*SUM_W +: SUM_W] = sum[c];
    end
  end

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign mem_we   = (state_r == B_ACC);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == B_OUT) && out_free;

  // line store of block sums
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[bx_r] <= sum_word;
    end
    if (q_pop) begin
      rd_data_r <= mem[q_bx];
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // load a finished pixel, or drop the one that was taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            pix_r   <= q_pix;
            bx_r    <= q_bx;
            by_r    <= q_by;
            flags_r <= q_flags;
            state_r <= B_ACC;
          end
        end
        B_ACC: begin
          if (flags_r.last) begin
            sum_r   <= sum;
            state_r <= B_MUL;
          end else begin
            state_r <= B_IDLE;
          end
        end
        B_MUL: begin
          for (int c = 0; c < NCH; c++) begin
            prod_r[c] <= PROD_W'(sum_r[c]) * PROD_W'(recip);
          end
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            out_pix_r.red   <= prod_r[0][SH +: CHAN_W];
            out_pix_r.green <= prod_r[1][SH +: CHAN_W];
            out_pix_r.blue  <= prod_r[2][SH +: CHAN_W];
            out_pix_r.alpha <= prod_r[3][SH +: CHAN_W];
            out_col_r       <= COORD_W'(bx_r);
            out_row_r       <= by_r;
            out_fend_r      <= flags_r.fend;
            state_r         <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_col   = out_col_r;
  assign out_row   = out_row_r;
  assign out_fend  = out_fend_r;

`ifndef NO_ASSERTIONS
  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == B_OUT)
    else $error("pixel shown without a finished division");

  a_acc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ACC) |-> $past(state_r) == B_IDLE)
    else $error("accumulate without a store read");
`endif

endmodule

/* rtl/supersample_box_downsampler_unit.sv */
// ----------------------------------------------------------------------------
// supersample_box_downsampler_unit
// Box-filter resolve of a supersampled rgba frame into one pixel per block.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one rgba supersample per word, raster order over a frame of
//           (target width * block side) x (target height * block side).
//   out_* : one averaged pixel per square block of supersamples, with its
//           column, row and a frame-end mark on the frame's last pixel.
//   cfg_* : write-only registers (block side, target width, target height),
//           written while no sample is in flight.
// Back end: each sample takes a read-modify-write of the block-sum line
//   store (B_IDLE reads, B_ACC writes), and the last sample of a block
//   adds the reciprocal multiply (B_MUL) and the output load (B_OUT), so
//   a new sample is taken only after the one before it is through.
// Result path: a block's last sample is popped in B_IDLE and passes B_ACC,
//   B_MUL and B_OUT to out_valid; B_OUT waits for a free output register.
// Reset and configuration: after reset and after every register write the
//   unit stalls its input while S_CALC, S_WRAP and the divider in S_DIV
//   rebuild the frame sizes and the block position. The sample position is
//   kept across writes; a coordinate outside the new frame restarts at zero.
// Stall: results wait in the output register; a 4-word queue keeps taking
//   samples until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module supersample_box_downsampler_unit #(
  parameter int MAX_WIDTH       = sbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SAMPLE_RATE = sbd_pkg::MAX_SAMPLE_RATE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [sbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbd_pkg::CFG_W-1:0]       cfg_wdata,
  // samples in
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sbd_pkg::CHAN_W-1:0]      in_sample_red,
  input  logic [sbd_pkg::CHAN_W-1:0]      in_sample_green,
  input  logic [sbd_pkg::CHAN_W-1:0]      in_sample_blue,
  input  logic [sbd_pkg::CHAN_W-1:0]      in_sample_alpha,
  // pixels out
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sbd_pkg::CHAN_W-1:0]      out_pixel_red,
  output logic [sbd_pkg::CHAN_W-1:0]      out_pixel_green,
  output logic [sbd_pkg::CHAN_W-1:0]      out_pixel_blue,
  output logic [sbd_pkg::CHAN_W-1:0]      out_pixel_alpha,
  output logic [sbd_pkg::COORD_W-1:0]     out_pixel_col,
  output logic [sbd_pkg::COORD_W-1:0]     out_pixel_row,
  output logic                            out_frame_end
);

  import sbd_pkg::*;

  localparam int BX_W   = $clog2(MAX_WIDTH);
  localparam int RATE_W = $clog2(MAX_SAMPLE_RATE + 1);
  localparam int FL_W   = $bits(blk_flags_t);
  localparam int PIX_W  = $bits(rgba_t);
  localparam int QW     = PIX_W + BX_W + COORD_W + FL_W;

  rgba_t              in_pix;
  logic               push;
  rgba_t              push_pix;
  logic [BX_W-1:0]    push_bx;
  logic [COORD_W-1:0] push_by;
  blk_flags_t         push_flags;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  logic [QW-1:0]      q_wdata;
  logic [QW-1:0]      q_rdata;
  rgba_t              q_pix;
  logic [BX_W-1:0]    q_bx;
  logic [COORD_W-1:0] q_by;
  blk_flags_t         q_flags;
  logic [RATE_W-1:0]  blk_rate;
  rgba_t              out_pix;

  // input word
  assign in_pix.red   = in_sample_red;
  assign in_pix.green = in_sample_green;
  assign in_pix.blue  = in_sample_blue;
  assign in_pix.alpha = in_sample_alpha;

  // front end: position tracking and tagging
  sbd_front #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_SAMPLE_RATE (MAX_SAMPLE_RATE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pix     (in_pix),
    .push       (push),
    .push_pix   (push_pix),
    .push_bx    (push_bx),
    .push_by    (push_by),
    .push_flags (push_flags),
    .q_full     (q_full),
    .blk_rate   (blk_rate)
  );

  // queue between front and back end
  assign q_wdata = {push_pix, push_bx, push_by, push_flags};

  sbd_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {q_pix, q_bx, q_by, q_flags} = q_rdata;

  // back end: accumulate, divide, output register
  sbd_back #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_SAMPLE_RATE (MAX_SAMPLE_RATE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_pix     (q_pix),
    .q_bx      (q_bx),
    .q_by      (q_by),
    .q_flags   (q_flags),
    .blk_rate  (blk_rate),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix),
    .out_col   (out_pixel_col),
    .out_row   (out_pixel_row),
    .out_fend  (out_frame_end)
  );

  // output word
  assign out_pixel_red   = out_pix.red;
  assign out_pixel_green = out_pix.green;
  assign out_pixel_blue  = out_pix.blue;
  assign out_pixel_alpha = out_pix.alpha;

endmodule
